// ===== hdl/z_score_normalizer_defines.svh =====
// Assertion macros for the z-score normalizer checker.
`ifndef Z_SCORE_NORMALIZER_DEFINES_SVH
`define Z_SCORE_NORMALIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ZSN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zsn assertion failed");

// Next-cycle implication.
`define ZSN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zsn assertion failed");

`endif

// ===== hdl/zsn_pkg.sv =====
package zsn_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int SAMPLE_W = 24;
  localparam int Z_W      = 21;
  localparam int SUM_W    = 30;
  localparam int DIFF_W   = 25;
  localparam int PROD_W   = 50;
  localparam int ACC_W    = 56;
  localparam int DIV_W    = 56;
  localparam int DIV_CW   = 6;
  localparam int ROOT_W   = 28;
  localparam int ROOT_CW  = 5;
  localparam int ZQ_W     = 41;

  localparam logic [DIV_CW-1:0] STEPS_MEAN = 6'd30;
  localparam logic [DIV_CW-1:0] STEPS_VAR  = 6'd56;
  localparam logic [DIV_CW-1:0] STEPS_Z    = 6'd41;

  localparam logic [ZQ_W-1:0] Z_POS_LIM = 41'd1048575;
  localparam logic [ZQ_W-1:0] Z_NEG_LIM = 41'd1048576;
  localparam logic [Z_W-1:0]  Z_MAX     = 21'h0FFFFF;
  localparam logic [Z_W-1:0]  Z_MIN     = 21'h100000;

  localparam logic [1:0] DIV_MEAN = 2'd0;
  localparam logic [1:0] DIV_VAR  = 2'd1;
  localparam logic [1:0] DIV_Z    = 2'd2;

  typedef struct packed {
    logic       store;
    logic       mark_ovf;
    logic       clr_set;
    logic       div_go;
    logic [1:0] div_sel;
    logic       ld_mean;
    logic       rd;
    logic       ld_diff;
    logic       ld_prod;
    logic       acc_add;
    logic       sqrt_go;
    logic       ld_spread;
    logic       ld_out;
    logic       last;
  } zsn_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic spread_zero;
    logic out_free;
  } zsn_stat_t;

endpackage

// ===== hdl/zsn_div.sv =====
module zsn_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [zsn_pkg::DIV_W-1:0]          dividend,
  input  logic [zsn_pkg::SAMPLE_W-1:0]       divisor,
  input  logic [zsn_pkg::DIV_CW-1:0]         steps,
  output logic                               done,
  output logic [zsn_pkg::DIV_W-1:0]          quotient
);

  localparam int VW = zsn_pkg::SAMPLE_W;
  localparam int DW = zsn_pkg::DIV_W;

  logic [VW-1:0]              rem_r, rem_nxt;
  logic [DW-1:0]              quo_r, quo_nxt;
  logic [VW-1:0]              dvs_r;
  logic [zsn_pkg::DIV_CW-1:0] cnt_r;
  logic                       busy_r, done_r;
  logic [VW:0]                sh, diff;

  // left-aligned dividend, one quotient bit per cycle
  always_comb begin
    sh   = {rem_r, quo_r[DW-1]};
    diff = sh - {1'b0, dvs_r};
    if (sh >= {1'b0, dvs_r}) begin
      rem_nxt = diff[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], 1'b1};
    end else begin
      rem_nxt = sh[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == zsn_pkg::DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/zsn_dp.sv =====
module zsn_dp #(
  parameter int CAPACITY = zsn_pkg::CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  zsn_pkg::zsn_cmd_t                     cmd,
  input  logic [$clog2(CAPACITY)-1:0]           addr,
  input  logic [$clog2(CAPACITY+1)-1:0]         count,
  input  logic [zsn_pkg::SAMPLE_W-1:0]          in_sample,
  output zsn_pkg::zsn_stat_t                    stat,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [zsn_pkg::Z_W-1:0]               out_z_score,
  output logic [zsn_pkg::SAMPLE_W-1:0]          out_mean_value,
  output logic [zsn_pkg::SAMPLE_W-1:0]          out_spread,
  output logic                                  out_zero_spread,
  output logic                                  out_overflowed,
  output logic                                  out_end_of_set
);

  localparam int SW = zsn_pkg::SAMPLE_W;
  localparam int RW = zsn_pkg::ROOT_W;

  logic [SW-1:0]                  mem [CAPACITY];
  logic [SW-1:0]                  rd_r;
  logic signed [zsn_pkg::SUM_W-1:0]  sum_r;
  logic [zsn_pkg::ACC_W-1:0]      acc_r;
  logic                           ovf_r;
  logic [SW-1:0]                  mean_r, spread_r;
  logic signed [zsn_pkg::DIFF_W-1:0] diff_r;
  logic signed [zsn_pkg::PROD_W-1:0] prod_r;

  logic [zsn_pkg::SUM_W-1:0]      sum_mag, q_mean;
  logic [zsn_pkg::DIFF_W-1:0]     mag;
  logic [zsn_pkg::DIV_W-1:0]      div_a, quo;
  logic [SW-1:0]                  div_b;
  logic [zsn_pkg::DIV_CW-1:0]     div_n;
  logic                           div_done;
  logic [zsn_pkg::ZQ_W-1:0]       q_z;
  logic [zsn_pkg::Z_W-1:0]        z_sat;

  logic [zsn_pkg::DIV_W-1:0]      sq_v_r;
  logic [RW:0]                    sq_rem_r;
  logic [RW-1:0]                  sq_q_r;
  logic [zsn_pkg::ROOT_CW-1:0]    sq_cnt_r;
  logic                           sq_busy_r, sq_done_r;
  logic [RW+2:0]                  sq_t, sq_trial, sq_d;

  logic                           out_valid_r;
  logic [zsn_pkg::Z_W-1:0]        out_z_r;
  logic [SW-1:0]                  out_mean_r, out_spread_r;
  logic                           out_zero_r, out_ovf_r, out_end_r;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[addr] <= in_sample;
    end
    if (cmd.rd) begin
      rd_r <= mem[addr];
    end
  end

  assign sum_mag = sum_r[zsn_pkg::SUM_W-1] ? zsn_pkg::SUM_W'(-sum_r)
                                          : zsn_pkg::SUM_W'(sum_r);
  assign mag     = diff_r[zsn_pkg::DIFF_W-1] ? zsn_pkg::DIFF_W'(-diff_r)
                                            : zsn_pkg::DIFF_W'(diff_r);

  always_comb begin
    case (cmd.div_sel)
      zsn_pkg::DIV_MEAN: begin
        div_a = {sum_mag, {(zsn_pkg::DIV_W-zsn_pkg::SUM_W){1'b0}}};
        div_b = SW'(count);
        div_n = zsn_pkg::STEPS_MEAN;
      end
      zsn_pkg::DIV_VAR: begin
        div_a = acc_r;
        div_b = SW'(count);
        div_n = zsn_pkg::STEPS_VAR;
      end
      default: begin
        div_a = {mag, {(zsn_pkg::DIV_W-zsn_pkg::DIFF_W){1'b0}}};
        div_b = spread_r;
        div_n = zsn_pkg::STEPS_Z;
      end
    endcase
  end

  zsn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .steps    (div_n),
    .done     (div_done),
    .quotient (quo)
  );

  assign q_mean = quo[zsn_pkg::SUM_W-1:0];
  assign q_z    = quo[zsn_pkg::ZQ_W-1:0];

  always_comb begin
    if (spread_r == '0) begin
      z_sat = '0;
    end else if (!diff_r[zsn_pkg::DIFF_W-1]) begin
      z_sat = (q_z > zsn_pkg::Z_POS_LIM) ? zsn_pkg::Z_MAX : q_z[zsn_pkg::Z_W-1:0];
    end else begin
      z_sat = (q_z > zsn_pkg::Z_NEG_LIM) ? zsn_pkg::Z_MIN
                                         : zsn_pkg::Z_W'(-q_z[zsn_pkg::Z_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      mean_r   <= '0;
      spread_r <= '0;
    end else begin
      if (cmd.clr_set) begin
        sum_r <= '0;
        acc_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        if (cmd.store) begin
          sum_r <= sum_r + zsn_pkg::SUM_W'($signed(in_sample));
        end
        if (cmd.mark_ovf) begin
          ovf_r <= 1'b1;
        end
        if (cmd.acc_add) begin
          acc_r <= acc_r + zsn_pkg::ACC_W'(unsigned'(prod_r));
        end
      end
      if (cmd.ld_mean) begin
        mean_r <= sum_r[zsn_pkg::SUM_W-1] ? SW'(-q_mean) : SW'(q_mean);
      end
      if (cmd.ld_spread) begin
        spread_r <= sq_q_r[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_diff) begin
      diff_r <= $signed({rd_r[SW-1], rd_r}) - $signed({mean_r[SW-1], mean_r});
    end
    if (cmd.ld_prod) begin
      prod_r <= diff_r * diff_r;
    end
  end

  // integer root, two radicand bits per cycle
  always_comb begin
    sq_t     = {sq_rem_r, sq_v_r[zsn_pkg::DIV_W-1 -: 2]};
    sq_trial = {1'b0, sq_q_r, 2'b01};
    sq_d     = sq_t - sq_trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_done_r <= 1'b0;
      sq_cnt_r  <= '0;
    end else begin
      sq_done_r <= 1'b0;
      if (cmd.sqrt_go) begin
        sq_busy_r <= 1'b1;
        sq_cnt_r  <= zsn_pkg::ROOT_CW'(RW - 1);
      end else if (sq_busy_r) begin
        sq_cnt_r <= sq_cnt_r - 1'b1;
        if (sq_cnt_r == '0) begin
          sq_busy_r <= 1'b0;
          sq_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_go) begin
      sq_v_r   <= quo;
      sq_rem_r <= '0;
      sq_q_r   <= '0;
    end else if (sq_busy_r) begin
      sq_v_r <= {sq_v_r[zsn_pkg::DIV_W-3:0], 2'b00};
      if (sq_t >= sq_trial) begin
        sq_rem_r <= sq_d[RW:0];
        sq_q_r   <= {sq_q_r[RW-2:0], 1'b1};
      end else begin
        sq_rem_r <= sq_t[RW:0];
        sq_q_r   <= {sq_q_r[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_z_r      <= z_sat;
      out_mean_r   <= mean_r;
      out_spread_r <= spread_r;
      out_zero_r   <= (spread_r == '0);
      out_ovf_r    <= ovf_r;
      out_end_r    <= cmd.last;
    end
  end

  assign stat.div_done    = div_done;
  assign stat.sqrt_done   = sq_done_r;
  assign stat.spread_zero = (spread_r == '0);
  assign stat.out_free    = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_z_score     = out_z_r;
  assign out_mean_value  = out_mean_r;
  assign out_spread      = out_spread_r;
  assign out_zero_spread = out_zero_r;
  assign out_overflowed  = out_ovf_r;
  assign out_end_of_set  = out_end_r;

endmodule

// ===== hdl/zsn_ctrl.sv =====
module zsn_ctrl #(
  parameter int CAPACITY = zsn_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_final_sample,
  output logic                           in_stall,
  input  zsn_pkg::zsn_stat_t             stat,
  output zsn_pkg::zsn_cmd_t              cmd,
  output logic [$clog2(CAPACITY)-1:0]    addr,
  output logic [$clog2(CAPACITY+1)-1:0]  count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_MEAN  = 4'd1;
  localparam logic [3:0] S_MEANW = 4'd2;
  localparam logic [3:0] S_VRD   = 4'd3;
  localparam logic [3:0] S_VDIFF = 4'd4;
  localparam logic [3:0] S_VSQ   = 4'd5;
  localparam logic [3:0] S_VACC  = 4'd6;
  localparam logic [3:0] S_VDIV  = 4'd7;
  localparam logic [3:0] S_VDIVW = 4'd8;
  localparam logic [3:0] S_SQRT  = 4'd9;
  localparam logic [3:0] S_SQRTW = 4'd10;
  localparam logic [3:0] S_ZRD   = 4'd11;
  localparam logic [3:0] S_ZDIFF = 4'd12;
  localparam logic [3:0] S_ZDIV  = 4'd13;
  localparam logic [3:0] S_ZDIVW = 4'd14;
  localparam logic [3:0] S_ZOUT  = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          accept, full, at_last;

  assign in_stall = (state_r != S_LOAD);
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CW'(CAPACITY));
  assign at_last  = ((CW'(idx_r) + 1'b1) == count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.div_sel = zsn_pkg::DIV_MEAN;
    addr      = idx_r;
    case (state_r)
      S_LOAD: begin
        addr = count_r[AW-1:0];
        if (accept) begin
          if (!full) begin
            cmd.store = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            cmd.mark_ovf = 1'b1;
          end
          if (in_final_sample) begin
            state_nxt = S_MEAN;
          end
        end
      end
      S_MEAN: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_MEANW;
      end
      S_MEANW: begin
        if (stat.div_done) begin
          cmd.ld_mean = 1'b1;
          idx_nxt     = '0;
          state_nxt   = S_VRD;
        end
      end
      S_VRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_VDIFF;
      end
      S_VDIFF: begin
        cmd.ld_diff = 1'b1;
        state_nxt   = S_VSQ;
      end
      S_VSQ: begin
        cmd.ld_prod = 1'b1;
        state_nxt   = S_VACC;
      end
      S_VACC: begin
        cmd.acc_add = 1'b1;
        if (at_last) begin
          state_nxt = S_VDIV;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_VRD;
        end
      end
      S_VDIV: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = zsn_pkg::DIV_VAR;
        state_nxt   = S_VDIVW;
      end
      S_VDIVW: begin
        cmd.div_sel = zsn_pkg::DIV_VAR;
        if (stat.div_done) begin
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_go = 1'b1;
        state_nxt   = S_SQRTW;
      end
      S_SQRTW: begin
        if (stat.sqrt_done) begin
          cmd.ld_spread = 1'b1;
          idx_nxt       = '0;
          state_nxt     = S_ZRD;
        end
      end
      S_ZRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_ZDIFF;
      end
      S_ZDIFF: begin
        cmd.ld_diff = 1'b1;
        state_nxt   = S_ZDIV;
      end
      S_ZDIV: begin
        cmd.div_sel = zsn_pkg::DIV_Z;
        if (stat.spread_zero) begin
          state_nxt = S_ZOUT;
        end else begin
          cmd.div_go = 1'b1;
          state_nxt  = S_ZDIVW;
        end
      end
      S_ZDIVW: begin
        cmd.div_sel = zsn_pkg::DIV_Z;
        if (stat.div_done) begin
          state_nxt = S_ZOUT;
        end
      end
      S_ZOUT: begin
        cmd.div_sel = zsn_pkg::DIV_Z;
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          cmd.last   = at_last;
          if (at_last) begin
            cmd.clr_set = 1'b1;
            count_nxt   = '0;
            state_nxt   = S_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_ZRD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign count = count_r;

endmodule

// ===== hdl/z_score_normalizer.sv =====
// channel | direction | handshake         | payload
// in_     | input     | in_valid/in_stall | in_sample, in_final_sample
// out_    | output    | out_valid/out_stall | out_z_score, out_mean_value, out_spread,
//         |           |                   |   out_zero_spread, out_overflowed, out_end_of_set
// During loading a sample is accepted whenever in_valid is high; the item marked final
// starts the computation. Then: mean divide, variance pass (read, difference, square and
// accumulate per sample), variance divide, root, and per z-score a divide on the shared
// one-bit-per-cycle divider (skipped when the spread is zero), plus any output stall.
// Input is stalled from the final item until the last z-score enters the output register.
// Synchronous active-low reset clears control state; the sample store needs no clearing.
module z_score_normalizer #(
  parameter int CAPACITY = zsn_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [zsn_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic                              in_final_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [zsn_pkg::Z_W-1:0]           out_z_score,
  output logic [zsn_pkg::SAMPLE_W-1:0]      out_mean_value,
  output logic [zsn_pkg::SAMPLE_W-1:0]      out_spread,
  output logic                              out_zero_spread,
  output logic                              out_overflowed,
  output logic                              out_end_of_set
);

  zsn_pkg::zsn_cmd_t                 cmd;
  zsn_pkg::zsn_stat_t                stat;
  logic [$clog2(CAPACITY)-1:0]       addr;
  logic [$clog2(CAPACITY+1)-1:0]     count;

  zsn_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_final_sample (in_final_sample),
    .in_stall        (in_stall),
    .stat            (stat),
    .cmd             (cmd),
    .addr            (addr),
    .count           (count)
  );

  zsn_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .addr            (addr),
    .count           (count),
    .in_sample       (in_sample),
    .stat            (stat),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_z_score     (out_z_score),
    .out_mean_value  (out_mean_value),
    .out_spread      (out_spread),
    .out_zero_spread (out_zero_spread),
    .out_overflowed  (out_overflowed),
    .out_end_of_set  (out_end_of_set)
  );

endmodule

// ===== hdl/zsn_chk.sv =====
`include "z_score_normalizer_defines.svh"

module zsn_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [zsn_pkg::SAMPLE_W-1:0] in_sample,
  input logic                         in_final_sample,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [zsn_pkg::Z_W-1:0]      out_z_score,
  input logic [zsn_pkg::SAMPLE_W-1:0] out_mean_value,
  input logic [zsn_pkg::SAMPLE_W-1:0] out_spread,
  input logic                         out_zero_spread,
  input logic                         out_overflowed,
  input logic                         out_end_of_set
);

  `ZSN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_z_score) && $stable(out_end_of_set))
  `ZSN_ASSERT_NOW(a_zero_spread, out_valid, out_zero_spread == (out_spread == '0))
  `ZSN_ASSERT_NOW(a_zero_z, out_valid && out_zero_spread, out_z_score == '0)
  `ZSN_ASSERT_NOW(a_no_load_mid_set, out_valid && !out_end_of_set, in_stall)

endmodule

bind z_score_normalizer zsn_chk u_zsn_chk (.*);
